>>> src/legser_pkg.sv
// Package: constants, types and weight tables for the Legendre series evaluator.
package legser_pkg;

  localparam int MAX_COEFFS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(MAX_COEFFS);
  localparam int CNT_W  = $clog2(MAX_COEFFS + 1);
  localparam int WGT_W  = FRAC_BITS + 2;
  localparam int MULB_W = DATA_W + 1;
  localparam int PROD_W = DATA_W + MULB_W;
  localparam int RND_W  = PROD_W + 1;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic REG_NUM_COEFFS = 1'b0;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } legser_action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_HI,
    ST_LOAD_LO,
    ST_MUL_A,
    ST_MUL_X,
    ST_SUB,
    ST_MUL_W,
    ST_RND_W,
    ST_ADD,
    ST_FIN_MUL,
    ST_FIN_RND,
    ST_FIN_ADD
  } legser_state_e;

  typedef enum logic {
    MA_C1,
    MA_RND
  } legser_mula_e;

  typedef enum logic [1:0] {
    MB_WA,
    MB_WB,
    MB_X
  } legser_mulb_e;

  typedef struct packed {
    legser_mula_e mul_a_sel;
    legser_mulb_e mul_b_sel;
    logic         mul_en;
    logic         rnd_en;
    logic         add_en;
    logic         add_sub;
  } legser_ctrl_t;

  // (nd-1)/nd, rounded to nearest
  function automatic logic [WGT_W-1:0] weight_a(input logic [IDX_W-1:0] nd);
    logic [WGT_W-1:0] w;
    case (nd)
      4'd2:    w = WGT_W'(((1  << FRAC_BITS) + 1) / 2);
      4'd3:    w = WGT_W'(((2  << FRAC_BITS) + 1) / 3);
      4'd4:    w = WGT_W'(((3  << FRAC_BITS) + 2) / 4);
      4'd5:    w = WGT_W'(((4  << FRAC_BITS) + 2) / 5);
      4'd6:    w = WGT_W'(((5  << FRAC_BITS) + 3) / 6);
      4'd7:    w = WGT_W'(((6  << FRAC_BITS) + 3) / 7);
      4'd8:    w = WGT_W'(((7  << FRAC_BITS) + 4) / 8);
      4'd9:    w = WGT_W'(((8  << FRAC_BITS) + 4) / 9);
      4'd10:   w = WGT_W'(((9  << FRAC_BITS) + 5) / 10);
      4'd11:   w = WGT_W'(((10 << FRAC_BITS) + 5) / 11);
      4'd12:   w = WGT_W'(((11 << FRAC_BITS) + 6) / 12);
      4'd13:   w = WGT_W'(((12 << FRAC_BITS) + 6) / 13);
      4'd14:   w = WGT_W'(((13 << FRAC_BITS) + 7) / 14);
      4'd15:   w = WGT_W'(((14 << FRAC_BITS) + 7) / 15);
      default: w = '0;
    endcase
    return w;
  endfunction

  // (2nd-1)/nd, rounded to nearest
  function automatic logic [WGT_W-1:0] weight_b(input logic [IDX_W-1:0] nd);
    logic [WGT_W-1:0] w;
    case (nd)
      4'd2:    w = WGT_W'(((3  << FRAC_BITS) + 1) / 2);
      4'd3:    w = WGT_W'(((5  << FRAC_BITS) + 1) / 3);
      4'd4:    w = WGT_W'(((7  << FRAC_BITS) + 2) / 4);
      4'd5:    w = WGT_W'(((9  << FRAC_BITS) + 2) / 5);
      4'd6:    w = WGT_W'(((11 << FRAC_BITS) + 3) / 6);
      4'd7:    w = WGT_W'(((13 << FRAC_BITS) + 3) / 7);
      4'd8:    w = WGT_W'(((15 << FRAC_BITS) + 4) / 8);
      4'd9:    w = WGT_W'(((17 << FRAC_BITS) + 4) / 9);
      4'd10:   w = WGT_W'(((19 << FRAC_BITS) + 5) / 10);
      4'd11:   w = WGT_W'(((21 << FRAC_BITS) + 5) / 11);
      4'd12:   w = WGT_W'(((23 << FRAC_BITS) + 6) / 12);
      4'd13:   w = WGT_W'(((25 << FRAC_BITS) + 6) / 13);
      4'd14:   w = WGT_W'(((27 << FRAC_BITS) + 7) / 14);
      4'd15:   w = WGT_W'(((29 << FRAC_BITS) + 7) / 15);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> src/legser_if.sv
// Interfaces: input item channel and result channel of the Legendre series evaluator.
interface legser_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [legser_pkg::IDX_W-1:0]        coef_index;
  logic signed [legser_pkg::DATA_W-1:0] coef_value;
  logic signed [legser_pkg::DATA_W-1:0] x_value;

  modport source (output valid, action, coef_index, coef_value, x_value, input ready);
  modport sink   (input valid, action, coef_index, coef_value, x_value, output ready);
endinterface

interface legser_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [legser_pkg::DATA_W-1:0] series_value;
  logic                                saturated;

  modport source (output valid, series_value, saturated, input ready);
  modport sink   (input valid, series_value, saturated, output ready);
endinterface

>>> src/legendre_series_eval_top.sv
// Top level: Legendre series evaluator, Clenshaw recursion on one shared multiplier.
// Usage: a write item (action 0) stores one signed Q16.16 coefficient and gives
// no result. An evaluate item (action 1) gives p(x) = sum c_k L_k(x) over num_coeffs
// coefficients (0 reads as 1, above 16 as 16), saturated, with a flag set if any product,
// sum or difference clipped. An evaluation keeps in_ch.ready low from its transaction until
// its result is written to the output register. Each recursion step runs three products
// through the single 32x33 multiplier, each followed by a rounding/saturation register, plus
// one subtract and one add on the shared adder. The result sits in an output register, so
// new items are taken while it waits; the next evaluation only stalls in its final add if
// the old result is still held.
// The coefficient store resets to all zeros; num_coeffs resets to 1 (APB address 0).
module legendre_series_eval_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  legser_in_if.sink                               in_ch,
  legser_out_if.source                            out_ch,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [legser_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [legser_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [legser_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                    pready
);

  localparam int DW = legser_pkg::DATA_W;
  localparam int IW = legser_pkg::IDX_W;
  localparam int CW = legser_pkg::CNT_W;

  // configuration
  logic [CW-1:0] num_coeffs_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == legser_pkg::REG_NUM_COEFFS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_coeffs_q <= CW'(1);
    end else if (cfg_wr) begin
      num_coeffs_q <= pwdata[CW-1:0];
    end
  end

  assign prdata = (paddr[2] == legser_pkg::REG_NUM_COEFFS) ?
                  legser_pkg::APB_DATA_W'(num_coeffs_q) : '0;

  // effective coefficient count, 1..MAX_COEFFS
  logic [CW-1:0] nc;
  always_comb begin
    if (num_coeffs_q == '0) begin
      nc = CW'(1);
    end else if (num_coeffs_q > CW'(legser_pkg::MAX_COEFFS)) begin
      nc = CW'(legser_pkg::MAX_COEFFS);
    end else begin
      nc = num_coeffs_q;
    end
  end

  legser_pkg::legser_state_e state_q, state_d;
  legser_pkg::legser_ctrl_t  ctrl;

  logic in_acc, out_free;
  assign in_ch.ready = (state_q == legser_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  logic out_valid_q;
  assign out_free = !out_valid_q || out_ch.ready;

  // coefficient store
  logic signed [DW-1:0] store_q [legser_pkg::MAX_COEFFS];
  logic [IW-1:0]        rd_addr;
  logic signed [DW-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < legser_pkg::MAX_COEFFS; i++) begin
        store_q[i] <= '0;
      end
    end else if (in_acc && (in_ch.action == legser_pkg::ACT_WRITE) &&
                 (CW'(in_ch.coef_index) < CW'(legser_pkg::MAX_COEFFS))) begin
      store_q[IW'(in_ch.coef_index)] <= in_ch.coef_value;
    end
  end

  logic [IW-1:0] k_q;

  always_comb begin
    case (state_q)
      legser_pkg::ST_LOAD_HI: rd_addr = IW'(nc - CW'(1));
      legser_pkg::ST_LOAD_LO: rd_addr = (nc >= CW'(2)) ? IW'(nc - CW'(2)) : '0;
      default:                rd_addr = k_q;
    endcase
  end
  assign rd_data = store_q[rd_addr];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      legser_pkg::ST_IDLE: begin
        if (in_acc && (in_ch.action == legser_pkg::ACT_EVAL)) state_d = legser_pkg::ST_LOAD_HI;
      end
      legser_pkg::ST_LOAD_HI: state_d = legser_pkg::ST_LOAD_LO;
      legser_pkg::ST_LOAD_LO: begin
        state_d = (nc >= CW'(3)) ? legser_pkg::ST_MUL_A : legser_pkg::ST_FIN_MUL;
      end
      legser_pkg::ST_MUL_A:   state_d = legser_pkg::ST_MUL_X;
      legser_pkg::ST_MUL_X:   state_d = legser_pkg::ST_SUB;
      legser_pkg::ST_SUB:     state_d = legser_pkg::ST_MUL_W;
      legser_pkg::ST_MUL_W:   state_d = legser_pkg::ST_RND_W;
      legser_pkg::ST_RND_W:   state_d = legser_pkg::ST_ADD;
      legser_pkg::ST_ADD: begin
        state_d = (k_q == '0) ? legser_pkg::ST_FIN_MUL : legser_pkg::ST_MUL_A;
      end
      legser_pkg::ST_FIN_MUL: state_d = legser_pkg::ST_FIN_RND;
      legser_pkg::ST_FIN_RND: state_d = legser_pkg::ST_FIN_ADD;
      legser_pkg::ST_FIN_ADD: begin
        if (out_free) state_d = legser_pkg::ST_IDLE;
      end
      default: state_d = legser_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= legser_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath control
  always_comb begin
    ctrl = '{mul_a_sel: legser_pkg::MA_C1, mul_b_sel: legser_pkg::MB_X,
             mul_en: 1'b0, rnd_en: 1'b0, add_en: 1'b0, add_sub: 1'b0};
    case (state_q)
      legser_pkg::ST_MUL_A: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_b_sel = legser_pkg::MB_WA;
      end
      legser_pkg::ST_MUL_X: begin
        ctrl.mul_en = 1'b1;
        ctrl.rnd_en = 1'b1;
      end
      legser_pkg::ST_SUB: begin
        ctrl.rnd_en  = 1'b1;
        ctrl.add_en  = 1'b1;
        ctrl.add_sub = 1'b1;
      end
      legser_pkg::ST_MUL_W: begin
        ctrl.mul_en    = 1'b1;
        ctrl.mul_a_sel = legser_pkg::MA_RND;
        ctrl.mul_b_sel = legser_pkg::MB_WB;
      end
      legser_pkg::ST_RND_W:   ctrl.rnd_en = 1'b1;
      legser_pkg::ST_ADD:     ctrl.add_en = 1'b1;
      legser_pkg::ST_FIN_MUL: ctrl.mul_en = 1'b1;
      legser_pkg::ST_FIN_RND: ctrl.rnd_en = 1'b1;
      legser_pkg::ST_FIN_ADD: ctrl.add_en = out_free;
      default: ;
    endcase
  end

  // shared multiplier
  logic signed [DW-1:0]                     c0_q, c1_q, t_q, x_q, r_q;
  logic signed [legser_pkg::PROD_W-1:0]     p_q, prod;
  logic signed [DW-1:0]                     mul_a;
  logic signed [legser_pkg::MULB_W-1:0]     mul_b;
  logic [IW-1:0]                            nd;

  assign nd = k_q + IW'(2);

  always_comb begin
    mul_a = (ctrl.mul_a_sel == legser_pkg::MA_RND) ? r_q : c1_q;
    case (ctrl.mul_b_sel)
      legser_pkg::MB_WA: mul_b = $signed(legser_pkg::MULB_W'(legser_pkg::weight_a(nd)));
      legser_pkg::MB_WB: mul_b = $signed(legser_pkg::MULB_W'(legser_pkg::weight_b(nd)));
      legser_pkg::MB_X:  mul_b = $signed({x_q[DW-1], x_q});
      default:           mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // round half up, floor shift, saturate
  logic signed [legser_pkg::RND_W-1:0] rnd_sum, rnd_shf;
  logic signed [DW-1:0]                rnd_val;
  logic                                rnd_clip;

  always_comb begin
    rnd_sum = legser_pkg::RND_W'(p_q) +
              (legser_pkg::RND_W'(1) <<< (legser_pkg::FRAC_BITS - 1));
    rnd_shf = rnd_sum >>> legser_pkg::FRAC_BITS;
    rnd_clip = (rnd_shf[legser_pkg::RND_W-1:DW-1] != '0) &&
               (rnd_shf[legser_pkg::RND_W-1:DW-1] != '1);
    if (rnd_clip) begin
      rnd_val = rnd_shf[legser_pkg::RND_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      rnd_val = rnd_shf[DW-1:0];
    end
  end

  // shared adder: coefficient minus product, or c0 plus product
  logic signed [DW:0]   add_a, add_b, add_sum;
  logic signed [DW-1:0] add_val;
  logic                 add_clip;

  always_comb begin
    add_a    = ctrl.add_sub ? {rd_data[DW-1], rd_data} : {c0_q[DW-1], c0_q};
    add_b    = {r_q[DW-1], r_q};
    add_sum  = ctrl.add_sub ? (add_a - add_b) : (add_a + add_b);
    add_clip = (add_sum[DW] != add_sum[DW-1]);
    if (add_clip) begin
      add_val = add_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      add_val = add_sum[DW-1:0];
    end
  end

  logic flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      k_q    <= '0;
    end else begin
      if (in_acc) begin
        flag_q <= 1'b0;
      end else if ((ctrl.rnd_en && rnd_clip) || (ctrl.add_en && add_clip)) begin
        flag_q <= 1'b1;
      end
      if (state_q == legser_pkg::ST_LOAD_LO) begin
        k_q <= IW'(nc - CW'(3));
      end else if ((state_q == legser_pkg::ST_ADD) && (k_q != '0)) begin
        k_q <= k_q - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= in_ch.x_value;
    if (ctrl.mul_en) p_q <= prod;
    if (ctrl.rnd_en) r_q <= rnd_val;
    case (state_q)
      legser_pkg::ST_LOAD_HI: c1_q <= (nc >= CW'(2)) ? rd_data : '0;
      legser_pkg::ST_LOAD_LO: c0_q <= rd_data;
      legser_pkg::ST_SUB:     t_q  <= add_val;
      legser_pkg::ST_ADD: begin
        c1_q <= add_val;
        c0_q <= t_q;
      end
      default: ;
    endcase
  end

  // result register
  logic signed [DW-1:0] series_q;
  logic                 sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == legser_pkg::ST_FIN_ADD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == legser_pkg::ST_FIN_ADD) && out_free) begin
      series_q <= add_val;
      sat_q    <= flag_q | add_clip;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.series_value = series_q;
  assign out_ch.saturated    = sat_q;

`ifndef ASSERT_OFF
  a_result_from_final_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == legser_pkg::ST_FIN_ADD))
    else $error("result appeared without a final add");

  a_eval_starts_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_ch.action == legser_pkg::ACT_EVAL)) |=> (state_q == legser_pkg::ST_LOAD_HI))
    else $error("evaluate transaction did not start the sequencer");

  a_last_step_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == legser_pkg::ST_ADD) && (k_q == '0)) |=> (state_q == legser_pkg::ST_FIN_MUL))
    else $error("recursion did not end after degree zero");
`endif

endmodule
